// ----- sv/qpf_pkg.sv -----
// Shared constants, payload types and the round/saturate helper for the
// three-point quadratic polar fit. No dependencies.
package qpf_pkg;

  localparam int IN_FRAC_BITS  = 8;
  localparam int OUT_FRAC_BITS = 24;

  localparam int SPEED_W  = 15;
  localparam int SINK_W   = 14;
  localparam int COEF_W   = 32;
  localparam int QB       = 34;               // quotient bits before rounding
  localparam int DIFF_W   = SPEED_W + 1;      // speed difference
  localparam int WDIFF_W  = SINK_W + 1;       // sink difference
  localparam int SQ_W     = 2 * SPEED_W;      // speed squared
  localparam int DSQ_W    = SQ_W + 1;         // difference of squares
  localparam int P12_W    = 2 * DIFF_W;
  localparam int DET_W    = 3 * DIFF_W;
  localparam int MDA_W    = 3 * SPEED_W;      // |det|
  localparam int NA_W     = DIFF_W + WDIFF_W;
  localparam int NAM_W    = NA_W - 1;
  localparam int A_SHIFT  = IN_FRAC_BITS + OUT_FRAC_BITS + 1;
  localparam int NAN_W    = NAM_W + A_SHIFT;
  localparam int CMPA_W   = NAN_W - QB + MDA_W;
  localparam int FIX_SHIFT = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int NB_W     = 64;
  localparam int NB_SHIFT = IN_FRAC_BITS - 1;
  localparam int NBN_W    = NB_W - 1 - NB_SHIFT;
  localparam int MDB_W    = SPEED_W;
  localparam int CMPB_W   = NBN_W - QB + MDB_W;
  localparam int C_SHIFT  = 2 * IN_FRAC_BITS - 1;
  localparam int PB_W     = COEF_W + DSQ_W;
  localparam int PCA_W    = COEF_W + SQ_W + 1;
  localparam int PCB_W    = COEF_W + DIFF_W;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [QB-1:0] POS_LIM = (QB)'({(COEF_W-1){1'b1}});
  localparam logic [QB-1:0] NEG_LIM = POS_LIM + (QB)'(1);

  typedef struct packed {
    coef_t value;
    logic  clip;
  } round_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  d23;
    logic [SPEED_W-1:0]        v3;
    logic [SQ_W-1:0]           v3sq;
    logic signed [SINK_W-1:0]  w3;
    logic signed [WDIFF_W-1:0] dw23;
    logic signed [DSQ_W-1:0]   dsq;
    logic                      dzero;
  } side_a_t;

  typedef struct packed {
    logic [MDA_W-1:0] rem;
    logic [MDA_W-1:0] md;
    logic [QB-1:0]    low;
    logic [QB-1:0]    q;
    logic             ovf;
    logic             neg;
    side_a_t          side;
  } diva_t;

  typedef struct packed {
    coef_t                    a;
    coef_t                    b;
    logic                     clip;
    logic                     dzero;
    logic                     sequal;
    logic [SPEED_W-1:0]       v3;
    logic [SQ_W-1:0]          v3sq;
    logic signed [SINK_W-1:0] w3;
  } side_t;

  typedef struct packed {
    logic [MDB_W-1:0] rem;
    logic [MDB_W-1:0] md;
    logic [QB-1:0]    low;
    logic [QB-1:0]    q;
    logic             ovf;
    logic             neg;
    side_t            side;
  } divb_t;

  // q holds the magnitude with one extra fraction bit; round half away from zero
  function automatic round_t round_sat(input logic neg, input logic [QB-1:0] q,
                                       input logic ovf);
    round_t        res;
    logic [QB:0]   inc;
    logic [QB-1:0] r;
    logic          big;
    inc = {1'b0, q} + (QB+1)'(1);
    r   = inc[QB:1];
    big = ovf | (neg ? (r > NEG_LIM) : (r > POS_LIM));
    res.clip = big;
    if (big) begin
      res.value = neg ? COEF_MIN : COEF_MAX;
    end else begin
      res.value = neg ? -$signed(r[COEF_W-1:0]) : $signed(r[COEF_W-1:0]);
    end
    return res;
  endfunction

endpackage

// ----- sv/quadratic_polar_fit.sv -----
// Three-point quadratic polar fit: fully pipelined datapath with two
// restoring dividers. Depends on qpf_pkg.
//
// Usage: present three (speed, sink) points on the in_ channel; one result
// (a, b, c and four flags) leaves on the out_ channel per input transfer.
// Both channels transfer when valid is high and stall is low.
// Throughput: one point set per cycle while out_stall does not hold the
// pipeline. Depth: 83 register stages from the input to the out_ register.
// Depth is set by the two bit-per-stage dividers (35 stages each, for a and
// for b) plus the product, rounding and output stages around them.
// The whole pipeline advances together; when the output register holds an
// untaken result and out_stall is high, every stage holds and in_stall is
// raised, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; payload registers
// are not reset. There is no configuration and no state between items.
module quadratic_polar_fit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [qpf_pkg::SPEED_W-1:0]           in_speed_one,
  input  logic signed [qpf_pkg::SINK_W-1:0]     in_sink_one,
  input  logic [qpf_pkg::SPEED_W-1:0]           in_speed_two,
  input  logic signed [qpf_pkg::SINK_W-1:0]     in_sink_two,
  input  logic [qpf_pkg::SPEED_W-1:0]           in_speed_three,
  input  logic signed [qpf_pkg::SINK_W-1:0]     in_sink_three,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qpf_pkg::COEF_W-1:0]     out_coef_quad,
  output logic signed [qpf_pkg::COEF_W-1:0]     out_coef_lin,
  output logic signed [qpf_pkg::COEF_W-1:0]     out_coef_const,
  output logic                                  out_polar_ok,
  output logic                                  out_det_zero,
  output logic                                  out_speeds_equal,
  output logic                                  out_clipped
);
  import qpf_pkg::*;

  logic en;

  // stage 1: differences
  logic                      s1_v_r;
  logic signed [DIFF_W-1:0]  s1_d12_r, s1_d23_r, s1_d31_r;
  logic signed [WDIFF_W-1:0] s1_dw13_r, s1_dw23_r;
  logic [SPEED_W-1:0]        s1_v2_r, s1_v3_r;
  logic signed [SINK_W-1:0]  s1_w3_r;

  // stage 2: first products
  logic                      s2_v_r;
  logic signed [P12_W-1:0]   s2_p12_r;
  logic signed [NA_W-1:0]    s2_m1_r, s2_m2_r;
  logic [SQ_W-1:0]           s2_v2sq_r, s2_v3sq_r;
  logic signed [DIFF_W-1:0]  s2_d23_r, s2_d31_r;
  logic [SPEED_W-1:0]        s2_v3_r;
  logic signed [SINK_W-1:0]  s2_w3_r;
  logic signed [WDIFF_W-1:0] s2_dw23_r;

  // stage 3: determinant, numerator of a
  logic                      s3_v_r;
  logic signed [DET_W-1:0]   s3_p_r;
  logic signed [NA_W-1:0]    s3_na_r;
  side_a_t                   s3_side_r;

  // stage 4: magnitudes for divider a
  logic                      s4_v_r;
  logic [MDA_W-1:0]          s4_md_r;
  logic [NAM_W-1:0]          s4_mn_r;
  logic                      s4_neg_r;
  side_a_t                   s4_side_r;

  logic  da_v_r [0:QB];
  diva_t da_r   [0:QB];

  // stages 5..8: a, then numerator of b
  logic                      s5_v_r;
  side_t                     s5_side_r;
  logic signed [DSQ_W-1:0]   s5_dsq_r;
  logic signed [WDIFF_W-1:0] s5_dw23_r;
  logic signed [DIFF_W-1:0]  s5_d23_r;

  logic                      s6_v_r;
  side_t                     s6_side_r;
  logic signed [PB_W-1:0]    s6_prod_r;
  logic signed [WDIFF_W-1:0] s6_dw23_r;
  logic signed [DIFF_W-1:0]  s6_d23_r;

  logic                      s7_v_r;
  side_t                     s7_side_r;
  logic signed [NB_W-1:0]    s7_nb_r;
  logic signed [DIFF_W-1:0]  s7_d23_r;

  logic                      s8_v_r;
  side_t                     s8_side_r;
  logic [NB_W-2:0]           s8_mag_r;
  logic [MDB_W-1:0]          s8_md_r;
  logic                      s8_neg_r;

  logic  db_v_r [0:QB];
  divb_t db_r   [0:QB];

  // stages 9..12: b, then numerator of c
  logic                      s9_v_r;
  side_t                     s9_side_r;

  logic                      s10_v_r;
  side_t                     s10_side_r;
  logic signed [PCA_W-1:0]   s10_pa_r;
  logic signed [PCB_W-1:0]   s10_pb_r;

  logic                      s11_v_r;
  side_t                     s11_side_r;
  logic signed [NB_W-1:0]    s11_nc_r;

  logic                      s12_v_r;
  side_t                     s12_side_r;
  logic [NB_W-2:0]           s12_mag_r;
  logic                      s12_neg_r;

  logic  out_valid_r;
  coef_t out_a_r, out_b_r, out_c_r;
  logic  out_ok_r, out_dzero_r, out_sequal_r, out_clip_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_valid;
      s1_d12_r  <= $signed({1'b0, in_speed_one}) - $signed({1'b0, in_speed_two});
      s1_d23_r  <= $signed({1'b0, in_speed_two}) - $signed({1'b0, in_speed_three});
      s1_d31_r  <= $signed({1'b0, in_speed_three}) - $signed({1'b0, in_speed_one});
      s1_dw13_r <= $signed({in_sink_one[SINK_W-1], in_sink_one})
                 - $signed({in_sink_three[SINK_W-1], in_sink_three});
      s1_dw23_r <= $signed({in_sink_two[SINK_W-1], in_sink_two})
                 - $signed({in_sink_three[SINK_W-1], in_sink_three});
      s1_v2_r   <= in_speed_two;
      s1_v3_r   <= in_speed_three;
      s1_w3_r   <= in_sink_three;
    end
  end

  // ---------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r    <= s1_v_r;
      s2_p12_r  <= s1_d12_r * s1_d23_r;
      s2_m1_r   <= s1_d23_r * s1_dw13_r;
      s2_m2_r   <= s1_d31_r * s1_dw23_r;
      s2_v2sq_r <= s1_v2_r * s1_v2_r;
      s2_v3sq_r <= s1_v3_r * s1_v3_r;
      s2_d23_r  <= s1_d23_r;
      s2_d31_r  <= s1_d31_r;
      s2_v3_r   <= s1_v3_r;
      s2_w3_r   <= s1_w3_r;
      s2_dw23_r <= s1_dw23_r;
    end
  end

  // ---------------- stage 3
  // det = -(d12 * d23 * d31); the sign is folded in at stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r          <= s2_v_r;
      s3_p_r          <= s2_p12_r * s2_d31_r;
      s3_na_r         <= s2_m1_r + s2_m2_r;
      s3_side_r.d23   <= s2_d23_r;
      s3_side_r.v3    <= s2_v3_r;
      s3_side_r.v3sq  <= s2_v3sq_r;
      s3_side_r.w3    <= s2_w3_r;
      s3_side_r.dw23  <= s2_dw23_r;
      s3_side_r.dsq   <= $signed({1'b0, s2_v2sq_r}) - $signed({1'b0, s2_v3sq_r});
      s3_side_r.dzero <= 1'b0;
    end
  end

  // ---------------- stage 4
  logic signed [DET_W-1:0] p_abs;
  logic signed [NA_W-1:0]  na_abs;
  logic                    na_pos, p_pos;
  side_a_t                 s4_side_nxt;

  assign p_abs  = s3_p_r[DET_W-1] ? -s3_p_r : s3_p_r;
  assign na_abs = s3_na_r[NA_W-1] ? -s3_na_r : s3_na_r;
  assign na_pos = !s3_na_r[NA_W-1] && (s3_na_r != '0);
  assign p_pos  = !s3_p_r[DET_W-1] && (s3_p_r != '0);

  always_comb begin
    s4_side_nxt       = s3_side_r;
    s4_side_nxt.dzero = (s3_p_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r    <= s3_v_r;
      s4_md_r   <= p_abs[MDA_W-1:0];
      s4_mn_r   <= na_abs[NAM_W-1:0];
      s4_neg_r  <= na_pos ^ p_pos;
      s4_side_r <= s4_side_nxt;
    end
  end

  // ---------------- divider a: |na| * 2^A_SHIFT / |det|
  logic [NAN_W-1:0] na_n;
  diva_t            da0_nxt;

  assign na_n = {s4_mn_r, {A_SHIFT{1'b0}}};

  always_comb begin
    da0_nxt      = '0;
    da0_nxt.rem  = MDA_W'(na_n[NAN_W-1:QB]);
    da0_nxt.md   = s4_md_r;
    da0_nxt.low  = na_n[QB-1:0];
    da0_nxt.ovf  = (CMPA_W)'(na_n[NAN_W-1:QB]) >= (CMPA_W)'(s4_md_r);
    da0_nxt.neg  = s4_neg_r;
    da0_nxt.side = s4_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      da_v_r[0] <= 1'b0;
    end else if (en) begin
      da_v_r[0] <= s4_v_r;
      da_r[0]   <= da0_nxt;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_diva
    logic [MDA_W:0] trial_w;
    logic           ge_w;
    diva_t          da_nxt;

    always_comb begin
      trial_w    = {da_r[j-1].rem, da_r[j-1].low[QB-j]};
      ge_w       = trial_w >= {1'b0, da_r[j-1].md};
      da_nxt     = da_r[j-1];
      da_nxt.rem = ge_w ? MDA_W'(trial_w - {1'b0, da_r[j-1].md}) : trial_w[MDA_W-1:0];
      da_nxt.q   = {da_r[j-1].q[QB-2:0], ge_w};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        da_v_r[j] <= 1'b0;
      end else if (en) begin
        da_v_r[j] <= da_v_r[j-1];
        da_r[j]   <= da_nxt;
      end
    end
  end

  // ---------------- stage 5: round a
  round_t ra;
  side_t  s5_side_nxt;

  assign ra = round_sat(da_r[QB].neg, da_r[QB].q, da_r[QB].ovf);

  always_comb begin
    s5_side_nxt.a      = da_r[QB].side.dzero ? coef_t'(0) : ra.value;
    s5_side_nxt.b      = '0;
    s5_side_nxt.clip   = !da_r[QB].side.dzero && ra.clip;
    s5_side_nxt.dzero  = da_r[QB].side.dzero;
    s5_side_nxt.sequal = (da_r[QB].side.d23 == '0);
    s5_side_nxt.v3     = da_r[QB].side.v3;
    s5_side_nxt.v3sq   = da_r[QB].side.v3sq;
    s5_side_nxt.w3     = da_r[QB].side.w3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r    <= da_v_r[QB];
      s5_side_r <= s5_side_nxt;
      s5_dsq_r  <= da_r[QB].side.dsq;
      s5_dw23_r <= da_r[QB].side.dw23;
      s5_d23_r  <= da_r[QB].side.d23;
    end
  end

  // ---------------- stages 6..8: numerator of b
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r    <= s5_v_r;
      s6_side_r <= s5_side_r;
      s6_prod_r <= s5_side_r.a * s5_dsq_r;
      s6_dw23_r <= s5_dw23_r;
      s6_d23_r  <= s5_d23_r;

      s7_v_r    <= s6_v_r;
      s7_side_r <= s6_side_r;
      s7_nb_r   <= (NB_W'(s6_dw23_r) <<< FIX_SHIFT) + NB_W'(s6_prod_r);
      s7_d23_r  <= s6_d23_r;

      s8_v_r    <= s7_v_r;
      s8_side_r <= s7_side_r;
      s8_mag_r  <= s7_nb_r[NB_W-1] ? (NB_W-1)'(-s7_nb_r) : s7_nb_r[NB_W-2:0];
      s8_md_r   <= s7_d23_r[DIFF_W-1] ? MDB_W'(-s7_d23_r) : s7_d23_r[MDB_W-1:0];
      s8_neg_r  <= (!s7_nb_r[NB_W-1] && (s7_nb_r != '0)) ^ s7_d23_r[DIFF_W-1];
    end
  end

  // ---------------- divider b: (|nb| >> NB_SHIFT) / |v2 - v3|
  logic [NBN_W-1:0] nb_n;
  divb_t            db0_nxt;

  assign nb_n = s8_mag_r[NB_W-2:NB_SHIFT];

  always_comb begin
    db0_nxt      = '0;
    db0_nxt.rem  = MDB_W'(nb_n[NBN_W-1:QB]);
    db0_nxt.md   = s8_md_r;
    db0_nxt.low  = nb_n[QB-1:0];
    db0_nxt.ovf  = (CMPB_W)'(nb_n[NBN_W-1:QB]) >= (CMPB_W)'(s8_md_r);
    db0_nxt.neg  = s8_neg_r;
    db0_nxt.side = s8_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_v_r[0] <= 1'b0;
    end else if (en) begin
      db_v_r[0] <= s8_v_r;
      db_r[0]   <= db0_nxt;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_divb
    logic [MDB_W:0] trial_w;
    logic           ge_w;
    divb_t          db_nxt;

    always_comb begin
      trial_w    = {db_r[j-1].rem, db_r[j-1].low[QB-j]};
      ge_w       = trial_w >= {1'b0, db_r[j-1].md};
      db_nxt     = db_r[j-1];
      db_nxt.rem = ge_w ? MDB_W'(trial_w - {1'b0, db_r[j-1].md}) : trial_w[MDB_W-1:0];
      db_nxt.q   = {db_r[j-1].q[QB-2:0], ge_w};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        db_v_r[j] <= 1'b0;
      end else if (en) begin
        db_v_r[j] <= db_v_r[j-1];
        db_r[j]   <= db_nxt;
      end
    end
  end

  // ---------------- stage 9: round b
  round_t rb;
  side_t  s9_side_nxt;

  assign rb = round_sat(db_r[QB].neg, db_r[QB].q, db_r[QB].ovf);

  always_comb begin
    s9_side_nxt      = db_r[QB].side;
    s9_side_nxt.b    = db_r[QB].side.sequal ? coef_t'(0) : rb.value;
    s9_side_nxt.clip = db_r[QB].side.clip || (!db_r[QB].side.sequal && rb.clip);
  end

  // ---------------- stages 9..12: numerator of c
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
      s12_v_r <= 1'b0;
    end else if (en) begin
      s9_v_r     <= db_v_r[QB];
      s9_side_r  <= s9_side_nxt;

      s10_v_r    <= s9_v_r;
      s10_side_r <= s9_side_r;
      s10_pa_r   <= s9_side_r.a * $signed({1'b0, s9_side_r.v3sq});
      s10_pb_r   <= s9_side_r.b * $signed({1'b0, s9_side_r.v3});

      s11_v_r    <= s10_v_r;
      s11_side_r <= s10_side_r;
      s11_nc_r   <= (NB_W'(s10_side_r.w3) <<< FIX_SHIFT) + NB_W'(s10_pa_r)
                  + (NB_W'(s10_pb_r) <<< IN_FRAC_BITS);

      s12_v_r    <= s11_v_r;
      s12_side_r <= s11_side_r;
      s12_mag_r  <= s11_nc_r[NB_W-1] ? (NB_W-1)'(-s11_nc_r) : s11_nc_r[NB_W-2:0];
      s12_neg_r  <= !s11_nc_r[NB_W-1] && (s11_nc_r != '0);
    end
  end

  // ---------------- output register: round c, flags
  round_t rc;
  logic   c_ovf;

  assign c_ovf = |s12_mag_r[NB_W-2:C_SHIFT+QB];
  assign rc    = round_sat(s12_neg_r, s12_mag_r[C_SHIFT+QB-1:C_SHIFT], c_ovf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r  <= s12_v_r;
      out_a_r      <= s12_side_r.a;
      out_b_r      <= s12_side_r.b;
      out_c_r      <= rc.value;
      out_ok_r     <= !s12_side_r.a[COEF_W-1] && (s12_side_r.a != '0)
                   && s12_side_r.b[COEF_W-1]
                   && !rc.value[COEF_W-1] && (rc.value != '0);
      out_dzero_r  <= s12_side_r.dzero;
      out_sequal_r <= s12_side_r.sequal;
      out_clip_r   <= s12_side_r.clip || rc.clip;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coef_quad    = out_a_r;
  assign out_coef_lin     = out_b_r;
  assign out_coef_const   = out_c_r;
  assign out_polar_ok     = out_ok_r;
  assign out_det_zero     = out_dzero_r;
  assign out_speeds_equal = out_sequal_r;
  assign out_clipped      = out_clip_r;

  // ---------------- assertions
  a_dzero_forces_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_det_zero |-> out_coef_quad == '0)
    else $error("det_zero result with nonzero a");

  a_sequal_forces_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speeds_equal |-> out_coef_lin == '0)
    else $error("speeds_equal result with nonzero b");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s12_v_r) && $stable(da_v_r[QB]) && $stable(s1_v_r))
    else $error("pipeline moved while blocked");

endmodule

// ----- bench/quadratic_polar_fit_tb.sv -----
// Testbench for quadratic_polar_fit: drives three-point polar sets and checks
// each fit against an in-bench predictor. Depends on qpf_pkg and the DUT.
module quadratic_polar_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qpf_pkg::*;

  typedef struct {
    logic [SPEED_W-1:0] v1, v2, v3;
    logic signed [SINK_W-1:0] w1, w2, w3;
  } points_t;

  typedef struct {
    coef_t a, b, c;
    logic ok, dzero, sequal, clip;
  } fit_t;

  // directed row: points plus an optional typed-in expectation
  typedef struct {
    points_t pts;
    logic    known;
    fit_t    fit;
  } row_t;

  localparam int NUM_RANDOM = 1000;
  localparam int LATENCY    = 83;
  localparam longint LIMIT  = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [SPEED_W-1:0] in_speed_one, in_speed_two, in_speed_three;
  logic signed [SINK_W-1:0] in_sink_one, in_sink_two, in_sink_three;
  coef_t out_coef_quad, out_coef_lin, out_coef_const;
  logic out_polar_ok, out_det_zero, out_speeds_equal, out_clipped;

  fit_t   fits_pending[$];
  int     errors = 0;
  int     results_seen = 0;
  longint cycles = 0;
  int     sink_wait = 0;
  int     sink_seen = 0;

  quadratic_polar_fit DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // round(n * 2^s / d), ties away from zero, saturated to 32 bits
  function automatic coef_t div_round(input longint n, input longint d, input int s,
                                      inout logic clip);
    logic [63:0] mn, md, q, r;
    logic neg, sat;
    longint v;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    neg = (n < 0) != (d < 0);
    q = mn / md;
    r = mn % md;
    sat = q > (64'd1 << 34);
    for (int i = 0; i <= s && !sat; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= md) begin
        r = r - md;
        q[0] = 1'b1;
      end
      if (q > (64'd1 << 34)) sat = 1;
    end
    if (sat) begin
      clip = 1;
      return neg ? COEF_MIN : COEF_MAX;
    end
    q = (q + 1) >> 1;
    v = neg ? -longint'(q) : longint'(q);
    if (v > 64'sd2147483647) begin
      clip = 1;
      return COEF_MAX;
    end
    if (v < -64'sd2147483648) begin
      clip = 1;
      return COEF_MIN;
    end
    return coef_t'(v);
  endfunction

  function automatic fit_t fit_parabola(input points_t p);
    fit_t f;
    longint v1, v2, v3, w1, w2, w3, det, na, nb, nc, dv, a, b;
    v1 = p.v1; v2 = p.v2; v3 = p.v3;
    w1 = p.w1; w2 = p.w2; w3 = p.w3;
    f.clip = 0;
    det = v1*v1*(v2-v3) + v2*v2*(v3-v1) + v3*v3*(v1-v2);
    f.dzero = det == 0;
    if (f.dzero) f.a = '0;
    else begin
      na = (v2-v3)*(w1-w3) + (v3-v1)*(w2-w3);
      f.a = div_round(-na, det, IN_FRAC_BITS + OUT_FRAC_BITS, f.clip);
    end
    a = f.a;
    dv = v2 - v3;
    f.sequal = dv == 0;
    if (f.sequal) f.b = '0;
    else begin
      nb = w2 * (64'sd1 <<< (OUT_FRAC_BITS+IN_FRAC_BITS)) - w3 * (64'sd1 <<< (OUT_FRAC_BITS+IN_FRAC_BITS))
         + a*(v2*v2 - v3*v3);
      f.b = div_round(-nb, dv * (64'sd1 <<< IN_FRAC_BITS), 0, f.clip);
    end
    b = f.b;
    nc = w3 * (64'sd1 <<< (OUT_FRAC_BITS+IN_FRAC_BITS)) + a*(v3*v3)
       + b*v3*(64'sd1 <<< IN_FRAC_BITS);
    f.c = div_round(-nc, 64'sd1 <<< (2*IN_FRAC_BITS), 0, f.clip);
    f.ok = f.a > 0 && f.b < 0 && f.c > 0;
    return f;
  endfunction

  task automatic send_points(input points_t p, input fit_t f);
    repeat ($urandom_range(0, 7) * $urandom_range(0, 1)) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid       <= 1;
    in_speed_one   <= p.v1;
    in_sink_one    <= p.w1;
    in_speed_two   <= p.v2;
    in_sink_two    <= p.w2;
    in_speed_three <= p.v3;
    in_sink_three  <= p.w3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fits_pending.push_back(f);
    @(negedge clk);
  endtask

  function automatic points_t rand_points();
    points_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // plausible polar: speeds and sinks in range
      p.v1 = SPEED_W'($urandom_range(0, 25600));
      p.v2 = SPEED_W'($urandom_range(0, 25600));
      p.v3 = SPEED_W'($urandom_range(0, 25600));
      p.w1 = SINK_W'($urandom_range(0, 10240) - 5120);
      p.w2 = SINK_W'($urandom_range(0, 10240) - 5120);
      p.w3 = SINK_W'($urandom_range(0, 10240) - 5120);
    end else begin
      {p.v1, p.v2, p.v3} = (3*SPEED_W)'({$urandom, $urandom});
      {p.w1, p.w2, p.w3} = (3*SINK_W)'({$urandom, $urandom});
    end
    case ($urandom_range(0, 9))
      0: p.v3 = p.v2;
      1: p.v1 = p.v2;
      2: p.v1 = p.v3;
      3: begin
        p.v1 = SPEED_W'($urandom_range(0, 15)); p.v2 = SPEED_W'($urandom_range(0, 15));
        p.v3 = SPEED_W'($urandom_range(0, 15));
      end
      default: ;
    endcase
    return p;
  endfunction

  // sink side: holds out_stall for a random wait before each result transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      sink_wait = $urandom_range(0, 7);
      sink_seen = results_seen;
    end else begin
      if (results_seen != sink_seen) begin
        sink_seen = results_seen;
        sink_wait = $urandom_range(0, 7);
      end
      if (out_valid && sink_wait > 0) begin
        out_stall <= 1;
        sink_wait--;
      end else out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (fits_pending.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        errors++;
      end else begin
        e = fits_pending.pop_front();
        if (out_coef_quad !== e.a || out_coef_lin !== e.b || out_coef_const !== e.c ||
            out_polar_ok !== e.ok || out_det_zero !== e.dzero ||
            out_speeds_equal !== e.sequal || out_clipped !== e.clip) begin
          $display("%0t: expected a=%0d b=%0d c=%0d ok=%b dz=%b se=%b cl=%b", $realtime,
                   e.a, e.b, e.c, e.ok, e.dzero, e.sequal, e.clip);
          $display("%0t:   actual a=%0d b=%0d c=%0d ok=%b dz=%b se=%b cl=%b", $realtime,
                   out_coef_quad, out_coef_lin, out_coef_const, out_polar_ok,
                   out_det_zero, out_speeds_equal, out_clipped);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    points_t p;
    fit_t f;
    rst_n = 0; in_valid = 0;
    in_speed_one = 0; in_speed_two = 0; in_speed_three = 0;
    in_sink_one = 0; in_sink_two = 0; in_sink_three = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1;

    // all-zero points: determinant zero, speeds equal, everything zero
    r.pts = '{0, 0, 0, 0, 0, 0}; r.known = 1;
    r.fit = '{0, 0, 0, 0, 1, 1, 0}; rows.push_back(r);
    r.known = 0;
    r.pts = '{15'd2560, 15'd5120, 15'd7680, -14'sd150, -14'sd200, -14'sd400}; rows.push_back(r);
    r.pts = '{15'd0, 15'd25600, 15'd12800, -14'sd5120, 14'sd5120, 14'sd0}; rows.push_back(r);
    r.pts = '{15'h7FFF, 15'd0, 15'd1, 14'sh1FFF, -14'sd8192, 14'sd1}; rows.push_back(r);
    r.pts = '{15'd1, 15'd2, 15'd3, -14'sd8192, 14'sd8191, -14'sd8192}; rows.push_back(r);
    r.pts = '{15'd1, 15'd2, 15'd2, 14'sd5, 14'sd3, 14'sd7}; rows.push_back(r);
    r.pts = '{15'd9, 15'd4, 15'd9, 14'sd5, 14'sd3, 14'sd7}; rows.push_back(r);
    r.pts = '{15'h7FFF, 15'h7FFE, 15'h7FFD, 14'sd8191, -14'sd8192, 14'sd8191}; rows.push_back(r);
    r.pts = '{15'h5555, 15'h2AAA, 15'h7FFF, 14'sh1555, 14'sh2AAA, 14'sh3FFF}; rows.push_back(r);
    r.pts = '{15'd0, 15'd1, 15'h7FFF, -14'sd1, 14'sd0, -14'sd8192}; rows.push_back(r);
    r.pts = '{15'd20, 15'd10, 15'd30, 14'sd100, 14'sd50, 14'sd100}; rows.push_back(r);

    foreach (rows[i]) begin
      f = rows[i].known ? rows[i].fit : fit_parabola(rows[i].pts);
      send_points(rows[i].pts, f);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      p = rand_points();
      send_points(p, fit_parabola(p));
    end
    in_valid <= 0;
    while (fits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d directed and %0d random point sets, %0d fits compared",
             rows.size(), NUM_RANDOM, results_seen);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
